>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by sorted_route_table_unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/srt_pkg.sv
// ---------------------------------------------------------------------------
// srt_pkg
// shared types and constants of the sorted route table
// ---------------------------------------------------------------------------
package srt_pkg;

    localparam int DATA_W = 8;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_VIA = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT
    } state_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_CLEAR,
        ACT_INSERT,
        ACT_REMOVE
    } cell_act_t;

    typedef struct packed {
        logic place;
        logic hit_origin;
        logic hit_route;
        logic dup_no_gain;
    } cell_flags_t;

endpackage

>>> rtl/srt_cell.sv
// ---------------------------------------------------------------------------
// srt_cell
// one table cell: holds a route, compares it with the key, shifts with
// its neighbors
// ---------------------------------------------------------------------------
module srt_cell #(
    parameter int KEY_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srt_pkg::cell_act_t         act,
    input  logic [KEY_W-1:0]           key_origin,
    input  logic [srt_pkg::DATA_W-1:0] key_hops,
    input  logic [KEY_W-1:0]           key_via,
    input  logic                       prev_place,
    input  logic                       shift_up,
    input  logic                       prev_valid,
    input  logic [KEY_W-1:0]           prev_origin,
    input  logic [srt_pkg::DATA_W-1:0] prev_hops,
    input  logic [KEY_W-1:0]           prev_via,
    input  logic                       next_valid,
    input  logic [KEY_W-1:0]           next_origin,
    input  logic [srt_pkg::DATA_W-1:0] next_hops,
    input  logic [KEY_W-1:0]           next_via,
    output logic                       valid,
    output logic [KEY_W-1:0]           origin,
    output logic [srt_pkg::DATA_W-1:0] hops,
    output logic [KEY_W-1:0]           via,
    output srt_pkg::cell_flags_t       flags
);
    import srt_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [KEY_W-1:0]   origin_reg;
    logic [KEY_W-1:0]   origin_next;
    logic [DATA_W-1:0]  hops_reg;
    logic [DATA_W-1:0]  hops_next;
    logic [KEY_W-1:0]   via_reg;
    logic [KEY_W-1:0]   via_next;
    logic               place;
    logic               hit_origin;
    logic               hit_route;

    assign place      = !valid_reg || (origin_reg > key_origin) ||
                        ((origin_reg == key_origin) && (hops_reg > key_hops));
    assign hit_origin = valid_reg && (origin_reg == key_origin);
    assign hit_route  = hit_origin && (via_reg == key_via);

    assign flags.place       = place;
    assign flags.hit_origin  = hit_origin;
    assign flags.hit_route   = hit_route;
    assign flags.dup_no_gain = hit_route && (hops_reg <= key_hops);

    always_comb
    begin
        valid_next  = valid_reg;
        origin_next = origin_reg;
        hops_next   = hops_reg;
        via_next    = via_reg;
        case (act)
            ACT_CLEAR:
            begin
                valid_next = 1'b0;
            end
            ACT_INSERT:
            begin
                if (prev_place)
                begin
                    valid_next  = prev_valid;
                    origin_next = prev_origin;
                    hops_next   = prev_hops;
                    via_next    = prev_via;
                end
                else if (place)
                begin
                    valid_next  = 1'b1;
                    origin_next = key_origin;
                    hops_next   = key_hops;
                    via_next    = key_via;
                end
            end
            ACT_REMOVE:
            begin
                if (shift_up)
                begin
                    valid_next  = next_valid;
                    origin_next = next_origin;
                    hops_next   = next_hops;
                    via_next    = next_via;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        origin_reg <= origin_next;
        hops_reg   <= hops_next;
        via_reg    <= via_next;
    end

    assign valid  = valid_reg;
    assign origin = origin_reg;
    assign hops   = hops_reg;
    assign via    = via_reg;

endmodule

>>> rtl/srt_gather.sv
// ---------------------------------------------------------------------------
// srt_gather
// prefix of a hit vector and readout of the first hit cell
// ---------------------------------------------------------------------------
module srt_gather #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 8
) (
    input  logic [DEPTH-1:0]           hit,
    input  logic [srt_pkg::DATA_W-1:0] hops [DEPTH],
    input  logic [KEY_W-1:0]           via [DEPTH],
    output logic [DEPTH-1:0]           prefix,
    output logic                       any,
    output logic [srt_pkg::DATA_W-1:0] found_hops,
    output logic [KEY_W-1:0]           found_via
);
    import srt_pkg::*;

    localparam int TREE_N  = 1 << $clog2(DEPTH);
    localparam int ENTRY_W = DATA_W + KEY_W;

    logic [DEPTH-1:0]   pre;
    logic [DEPTH-1:0]   first;
    logic [ENTRY_W-1:0] tree [TREE_N];

    // log-step prefix or
    always_comb
    begin
        pre = hit;
        for (int k = 1; k < DEPTH; k = k * 2)
        begin
            pre = pre | (pre << k);
        end
    end

    assign first = hit & ~(pre << 1);

    // or tree over the one-hot selected entries
    always_comb
    begin
        for (int j = 0; j < TREE_N; j++)
        begin
            tree[j] = '0;
        end
        for (int j = 0; j < DEPTH; j++)
        begin
            tree[j] = first[j] ? {hops[j], via[j]} : '0;
        end
        for (int w = TREE_N / 2; w >= 1; w = w / 2)
        begin
            for (int j = 0; j < w; j++)
            begin
                tree[j] = tree[2*j] | tree[2*j+1];
            end
        end
    end

    assign prefix     = pre;
    assign any        = |hit;
    assign found_hops = tree[0][ENTRY_W-1:KEY_W];
    assign found_via  = tree[0][KEY_W-1:0];

endmodule

>>> rtl/sorted_route_table_unit.sv
// ---------------------------------------------------------------------------
// sorted_route_table_unit
// route table kept packed and sorted by origin, then hop count
// ---------------------------------------------------------------------------
// Each item is a command (clear, insert, delete, lookup by origin, lookup by
// origin and next node) and gives exactly one result item. The table is a
// row of TABLE_DEPTH cells that all compare against the item's key at once
// and shift their routes to the neighbor cell, so one pass through the row
// does a whole insert or delete. An item is accepted in the idle state and
// then takes one pass through the cell row; no new item is accepted until
// its result is written. An insert that replaces a route of the same origin
// and next node with more hops does a removal pass, then an insertion pass.
// The pass that writes the result waits until the previous one is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_route_table_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int NODE_BITS   = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [srt_pkg::CMD_W-1:0]  command,
    input  logic [srt_pkg::DATA_W-1:0] route_origin,
    input  logic [srt_pkg::DATA_W-1:0] route_hops,
    input  logic [srt_pkg::DATA_W-1:0] route_via,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       success,
    output logic [srt_pkg::DATA_W-1:0] found_hops,
    output logic [srt_pkg::DATA_W-1:0] found_via
);
    import srt_pkg::*;

    localparam int KEY_W = (NODE_BITS < DATA_W) ? NODE_BITS : DATA_W;

    state_t             state_reg;
    state_t             state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [KEY_W-1:0]   key_origin_reg;
    logic [DATA_W-1:0]  key_hops_reg;
    logic [KEY_W-1:0]   key_via_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               success_reg;
    logic               success_next;
    logic [DATA_W-1:0]  found_hops_reg;
    logic [DATA_W-1:0]  found_hops_next;
    logic [DATA_W-1:0]  found_via_reg;
    logic [DATA_W-1:0]  found_via_next;

    cell_act_t          act;
    logic               emit;
    logic               out_free;

    logic               valid_w  [TABLE_DEPTH];
    logic [KEY_W-1:0]   origin_w [TABLE_DEPTH];
    logic [DATA_W-1:0]  hops_w   [TABLE_DEPTH];
    logic [KEY_W-1:0]   via_w    [TABLE_DEPTH];
    cell_flags_t        flags_w  [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] place_vec;
    logic [TABLE_DEPTH-1:0] origin_vec;
    logic [TABLE_DEPTH-1:0] route_vec;
    logic [TABLE_DEPTH-1:0] no_gain_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] prefix_vec;

    logic               gather_any;
    logic [DATA_W-1:0]  gather_hops;
    logic [KEY_W-1:0]   gather_via;
    logic               place_any;
    logic               no_gain_any;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg        <= command;
            key_origin_reg <= route_origin[KEY_W-1:0];
            key_hops_reg   <= route_hops;
            key_via_reg    <= route_via[KEY_W-1:0];
        end
    end

    // cell row
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic              prev_place;
        logic              prev_valid;
        logic [KEY_W-1:0]  prev_origin;
        logic [DATA_W-1:0] prev_hops;
        logic [KEY_W-1:0]  prev_via;
        logic              next_valid;
        logic [KEY_W-1:0]  next_origin;
        logic [DATA_W-1:0] next_hops;
        logic [KEY_W-1:0]  next_via;

        if (i == 0)
        begin : g_head
            assign prev_place  = 1'b0;
            assign prev_valid  = 1'b0;
            assign prev_origin = '0;
            assign prev_hops   = '0;
            assign prev_via    = '0;
        end
        else
        begin : g_body
            assign prev_place  = flags_w[i-1].place;
            assign prev_valid  = valid_w[i-1];
            assign prev_origin = origin_w[i-1];
            assign prev_hops   = hops_w[i-1];
            assign prev_via    = via_w[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign next_valid  = 1'b0;
            assign next_origin = '0;
            assign next_hops   = '0;
            assign next_via    = '0;
        end
        else
        begin : g_link
            assign next_valid  = valid_w[i+1];
            assign next_origin = origin_w[i+1];
            assign next_hops   = hops_w[i+1];
            assign next_via    = via_w[i+1];
        end

        srt_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .act         (act),
            .key_origin  (key_origin_reg),
            .key_hops    (key_hops_reg),
            .key_via     (key_via_reg),
            .prev_place  (prev_place),
            .shift_up    (prefix_vec[i]),
            .prev_valid  (prev_valid),
            .prev_origin (prev_origin),
            .prev_hops   (prev_hops),
            .prev_via    (prev_via),
            .next_valid  (next_valid),
            .next_origin (next_origin),
            .next_hops   (next_hops),
            .next_via    (next_via),
            .valid       (valid_w[i]),
            .origin      (origin_w[i]),
            .hops        (hops_w[i]),
            .via         (via_w[i]),
            .flags       (flags_w[i])
        );

        assign valid_vec[i]   = valid_w[i];
        assign place_vec[i]   = flags_w[i].place;
        assign origin_vec[i]  = flags_w[i].hit_origin;
        assign route_vec[i]   = flags_w[i].hit_route;
        assign no_gain_vec[i] = flags_w[i].dup_no_gain;
    end

    assign hit_vec     = (cmd_reg == CMD_LOOKUP) ? origin_vec : route_vec;
    assign place_any   = |place_vec;
    assign no_gain_any = |no_gain_vec;

    srt_gather #(
        .DEPTH (TABLE_DEPTH),
        .KEY_W (KEY_W)
    ) u_gather (
        .hit        (hit_vec),
        .hops       (hops_w),
        .via        (via_w),
        .prefix     (prefix_vec),
        .any        (gather_any),
        .found_hops (gather_hops),
        .found_via  (gather_via)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    if ((cmd_reg == CMD_INSERT) && gather_any && !no_gain_any)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        act             = ACT_HOLD;
        emit            = 1'b0;
        success_next    = 1'b0;
        found_hops_next = '0;
        found_via_next  = '0;
        case (state_reg)
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            act          = ACT_CLEAR;
                            success_next = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            if (no_gain_any)
                            begin
                                act = ACT_HOLD;
                            end
                            else if (gather_any)
                            begin
                                act  = ACT_REMOVE;
                                emit = 1'b0;
                            end
                            else
                            begin
                                act          = ACT_INSERT;
                                success_next = place_any;
                            end
                        end
                        CMD_DELETE:
                        begin
                            act          = ACT_REMOVE;
                            success_next = gather_any;
                        end
                        CMD_LOOKUP, CMD_LOOKUP_VIA:
                        begin
                            success_next    = gather_any;
                            found_hops_next = gather_hops;
                            found_via_next  = DATA_W'(gather_via);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    act          = ACT_INSERT;
                    emit         = 1'b1;
                    success_next = place_any;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            success_reg    <= success_next;
            found_hops_reg <= found_hops_next;
            found_via_reg  <= found_via_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign success    = success_reg;
    assign found_hops = found_hops_reg;
    assign found_via  = found_via_reg;

    `ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_reg == ST_EXEC)
    `ASSERT_ALWAYS(a_packed, clk, rst_n, ((valid_vec + 1'b1) & valid_vec) == '0)
    `ASSERT_ALWAYS(a_route_unique, clk, rst_n, $countones(route_vec) <= 1)
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_valid_reg && !success_reg, found_hops_reg == '0 && found_via_reg == '0)

endmodule

>>> tb/sorted_route_table_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_route_table_unit_tb
// self-checking bench for the sorted route table
// ---------------------------------------------------------------------------
// Sends route commands through the valid/ready input and compares every
// result item with a table model kept inside the scoreboard class. A short
// directed run fills the table and walks through replacement, rejection,
// overflow, delete, lookup, clear and unused commands. Random commands follow
// on small address pools to keep the table crowded. Both sides idle at random
// in two phases, and in the third the receiver holds off for one long stretch.
// ---------------------------------------------------------------------------
module sorted_route_table_unit_tb;
    import srt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int ITEMS_PER_RUN = 517;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [DATA_W-1:0] node_t;

    typedef struct packed {
        logic  ok;
        node_t hops;
        node_t via;
    } route_reply_t;

    class route_table_checker;
        node_t        row_origin[TABLE_DEPTH];
        node_t        row_hops[TABLE_DEPTH];
        node_t        row_via[TABLE_DEPTH];
        bit           row_used[TABLE_DEPTH];
        route_reply_t pending_replies[$];
        int           fault_count;

        function new();
            fault_count = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                row_origin[i] = '0;
                row_hops[i]   = '0;
                row_via[i]    = '0;
                row_used[i]   = 1'b0;
            end
        endfunction

        function int find_route(node_t origin, node_t via, bit match_via);
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (row_used[i] && row_origin[i] == origin && (!match_via || row_via[i] == via))
                    return i;
            end
            return -1;
        endfunction

        // shift up and free the last row
        function void drop_row(int idx);
            for (int i = idx; i < TABLE_DEPTH - 1; i++)
            begin
                row_origin[i] = row_origin[i+1];
                row_hops[i]   = row_hops[i+1];
                row_via[i]    = row_via[i+1];
                row_used[i]   = row_used[i+1];
            end
            row_origin[TABLE_DEPTH-1] = '0;
            row_hops[TABLE_DEPTH-1]   = '0;
            row_via[TABLE_DEPTH-1]    = '0;
            row_used[TABLE_DEPTH-1]   = 1'b0;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, node_t origin, node_t hops,
                                   node_t via);
            route_reply_t reply;
            int           idx;
            int           pos;
            reply = '0;
            case (cmd)
                CMD_CLEAR:
                begin
                    wipe_table();
                    reply.ok = 1'b1;
                end
                CMD_INSERT:
                begin
                    reply.ok = 1'b1;
                    idx = find_route(origin, via, 1'b1);
                    if (idx >= 0)
                    begin
                        if (row_hops[idx] <= hops)
                            reply.ok = 1'b0;
                        else
                            drop_row(idx);
                    end
                    if (reply.ok)
                    begin
                        pos = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            if (pos < 0 && (!row_used[i] || row_origin[i] > origin ||
                                (row_origin[i] == origin && row_hops[i] > hops)))
                                pos = i;
                        end
                        if (pos < 0)
                            reply.ok = 1'b0;
                        else
                        begin
                            for (int i = TABLE_DEPTH - 1; i > pos; i--)
                            begin
                                row_origin[i] = row_origin[i-1];
                                row_hops[i]   = row_hops[i-1];
                                row_via[i]    = row_via[i-1];
                                row_used[i]   = row_used[i-1];
                            end
                            row_origin[pos] = origin;
                            row_hops[pos]   = hops;
                            row_via[pos]    = via;
                            row_used[pos]   = 1'b1;
                        end
                    end
                end
                CMD_DELETE:
                begin
                    idx = find_route(origin, via, 1'b1);
                    if (idx >= 0)
                    begin
                        drop_row(idx);
                        reply.ok = 1'b1;
                    end
                end
                CMD_LOOKUP, CMD_LOOKUP_VIA:
                begin
                    idx = find_route(origin, via, cmd == CMD_LOOKUP_VIA);
                    if (idx >= 0)
                    begin
                        reply.ok   = 1'b1;
                        reply.hops = row_hops[idx];
                        reply.via  = row_via[idx];
                    end
                end
                default:
                begin
                end
            endcase
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic ok, node_t hops, node_t via);
            route_reply_t want;
            if (pending_replies.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result item: ok=%0b hops=%0d via=%0d", ok, hops, via);
                return;
            end
            want = pending_replies.pop_front();
            if (ok !== want.ok || hops !== want.hops || via !== want.via)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: expected ok=%0b hops=%0d via=%0d, got ok=%0b hops=%0d via=%0d",
                             want.ok, want.hops, want.via, ok, hops, via);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CMD_W-1:0]  command;
    node_t             route_origin;
    node_t             route_hops;
    node_t             route_via;
    logic              out_valid;
    logic              out_ready;
    logic              success;
    node_t             found_hops;
    node_t             found_via;

    route_table_checker table_check;
    int                 sender_idle_pct;
    int                 receiver_idle_pct;
    bit                 long_hold_request;
    int                 hold_left;

    sorted_route_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NODE_BITS(DATA_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .route_origin(route_origin),
        .route_hops(route_hops),
        .route_via(route_via),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .success(success),
        .found_hops(found_hops),
        .found_via(found_via)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_route(input logic [CMD_W-1:0] cmd, input node_t origin,
                              input node_t hops, input node_t via);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        route_origin <= origin;
        route_hops   <= hops;
        route_via    <= via;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        table_check.note_command(cmd, origin, hops, via);
    endtask

    // small address pools keep the table crowded
    task automatic run_phase(input int count);
        int                pick;
        logic [CMD_W-1:0]  cmd;
        node_t             origin;
        node_t             hops;
        node_t             via;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                cmd = CMD_CLEAR;
            else if (pick < 50)
                cmd = CMD_INSERT;
            else if (pick < 65)
                cmd = CMD_DELETE;
            else if (pick < 80)
                cmd = CMD_LOOKUP;
            else if (pick < 96)
                cmd = CMD_LOOKUP_VIA;
            else
                cmd = CMD_W'($urandom_range(int'(CMD_LOOKUP_VIA) + 1, (1 << CMD_W) - 1));
            origin = ($urandom_range(0, 99) < 75) ? node_t'($urandom_range(0, 11))
                                                  : node_t'($urandom_range(0, 255));
            hops   = ($urandom_range(0, 99) < 70) ? node_t'($urandom_range(0, 7))
                                                  : node_t'($urandom_range(0, 255));
            via    = ($urandom_range(0, 99) < 70) ? node_t'($urandom_range(0, 3))
                                                  : node_t'($urandom_range(0, 255));
            send_route(cmd, origin, hops, via);
        end
    endtask

    // result side: check, then pick ready for the next cycle
    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                table_check.check_reply(success, found_hops, found_via);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        table_check       = new();
        sender_idle_pct   = 38;
        receiver_idle_pct = 56;
        long_hold_request = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_CLEAR;
        route_origin <= '0;
        route_hops   <= '0;
        route_via    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // lookup on an empty table
        send_route(CMD_LOOKUP_VIA, 8'd0, 8'd0, 8'd0);
        // fill in descending order, origins 0..255
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            send_route(CMD_INSERT, node_t'(17 * i), node_t'(255 - 17 * i), node_t'(17 * i));
        // replace with fewer hops
        send_route(CMD_INSERT, 8'd0, 8'd254, 8'd0);
        // same route, hops not better
        send_route(CMD_INSERT, 8'd255, 8'd0, 8'd255);
        // full table, lands on the last row
        send_route(CMD_INSERT, 8'd254, 8'd7, 8'd1);
        // full table, sorts after everything
        send_route(CMD_INSERT, 8'd255, 8'd9, 8'd3);
        send_route(CMD_DELETE, 8'd0, 8'd0, 8'd0);
        send_route(CMD_LOOKUP, 8'd254, 8'd0, 8'd0);
        for (int unused_cmd = int'(CMD_LOOKUP_VIA) + 1; unused_cmd < (1 << CMD_W);
             unused_cmd++)
            send_route(CMD_W'(unused_cmd), 8'hA5, 8'h5A, 8'hFF);
        send_route(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        send_route(CMD_LOOKUP, 8'd34, 8'd0, 8'd0);

        run_phase(ITEMS_PER_RUN);
        sender_idle_pct   = 56;
        receiver_idle_pct = 38;
        run_phase(ITEMS_PER_RUN);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        long_hold_request = 1'b1;
        run_phase(ITEMS_PER_RUN);

        in_valid <= 1'b0;
        while (table_check.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_check.fault_count == 0 && table_check.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/srt_gather.sv
rtl/sorted_route_table_unit.sv
tb/sorted_route_table_unit_tb.sv
